>>> design/rtg_pkg.sv
// Shared constants and types of the ray tile generator
package rtg_pkg;

    localparam int RAYS_ACROSS_DEF    = 2;
    localparam int RAYS_DOWN_DEF      = 2;
    localparam int MAX_IMAGE_SIDE_DEF = 4096;

    localparam int MAX_LANES = 4;
    localparam int TILE_W    = 11;
    localparam int PIX_W     = 13;
    localparam int SIDE_W    = 15;
    localparam int IMG_W     = 13;
    localparam int TCNT_W    = 12;
    localparam int IDX_W     = 22;
    localparam int COMP_W    = 20;
    localparam int VEC_W     = 60;
    localparam int CFG_IDX_W = 3;

    localparam int PROD_W = 34;
    localparam int T_W    = 36;
    localparam int MAG_W  = 35;
    localparam int SH_W   = 3;
    localparam int M30_W  = 30;
    localparam int SQ_W   = 60;
    localparam int SUM_W  = 62;
    localparam int ROOT_W = 31;
    localparam int FRAC_W = 18;
    localparam int NUM_W  = 49;
    localparam int Q_W    = 19;

    localparam int PRE_LAT  = 6;
    localparam int DIV_LAT  = Q_W + 1;
    localparam int LANE_LAT = PRE_LAT + ROOT_W + DIV_LAT + 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILES_ACROSS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILES_DOWN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_LEFT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_STEP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UP_STEP      = 3'd6;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic             act;
    } lane_req_t;

endpackage

>>> design/ray_tile_generator.sv
// Ray tile generator top level: registers, tile setup, lanes and packet merge
//
//   Channel  Dir  Handshake              Payload
//   in       in   in_valid / in_ready    tile_column, tile_row
//   out      out  out_valid / out_ready  lane0..3_direction, active_mask,
//                                        packet_index, tile_out_of_range
//   cfg      in   cfg_write              cfg_index, cfg_data
//
// One packet per cycle while the output is not stalled; each lane holds the
// bit-per-stage square root and divider pipelines.
// The whole pipeline holds while a finished packet waits on out_ready.
// Reset clears stage valid bits and loads the register defaults.
module ray_tile_generator #(
    parameter int RAYS_ACROSS    = rtg_pkg::RAYS_ACROSS_DEF,
    parameter int RAYS_DOWN      = rtg_pkg::RAYS_DOWN_DEF,
    parameter int MAX_IMAGE_SIDE = rtg_pkg::MAX_IMAGE_SIDE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rtg_pkg::TILE_W-1:0]      tile_column,
    input  logic [rtg_pkg::TILE_W-1:0]      tile_row,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [rtg_pkg::VEC_W-1:0]       lane0_direction,
    output logic [rtg_pkg::VEC_W-1:0]       lane1_direction,
    output logic [rtg_pkg::VEC_W-1:0]       lane2_direction,
    output logic [rtg_pkg::VEC_W-1:0]       lane3_direction,
    output logic [rtg_pkg::MAX_LANES-1:0]   active_mask,
    output logic [rtg_pkg::IDX_W-1:0]       packet_index,
    output logic                            tile_out_of_range,
    input  logic                            cfg_write,
    input  logic [rtg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rtg_pkg::VEC_W-1:0]       cfg_data
);

    localparam int NL     = (RAYS_ACROSS * RAYS_DOWN < rtg_pkg::MAX_LANES)
                            ? RAYS_ACROSS * RAYS_DOWN : rtg_pkg::MAX_LANES;
    localparam int LAT    = rtg_pkg::LANE_LAT;
    localparam int PXW    = rtg_pkg::PIX_W;
    localparam int SDW    = rtg_pkg::SIDE_W;
    localparam int IW     = rtg_pkg::IDX_W;
    localparam int VW     = rtg_pkg::VEC_W;
    localparam int ML     = rtg_pkg::MAX_LANES;
    localparam int PROD_I = rtg_pkg::TILE_W + rtg_pkg::TCNT_W;

    logic [rtg_pkg::IMG_W-1:0]  image_width_reg;
    logic [rtg_pkg::IMG_W-1:0]  image_height_reg;
    logic [rtg_pkg::TCNT_W-1:0] tiles_across_reg;
    logic [rtg_pkg::TCNT_W-1:0] tiles_down_reg;
    logic [VW-1:0]              top_left_reg;
    logic [VW-1:0]              right_step_reg;
    logic [VW-1:0]              up_step_reg;

    logic                       en;
    logic                       oor;
    logic [SDW-1:0]             w_sat;
    logic [SDW-1:0]             h_sat;
    logic [ML-1:0]              mask_next;
    logic [IW-1:0]              idx_next;
    logic [PROD_I-1:0]          idx_prod;

    logic                       valid_reg [LAT];
    logic [ML-1:0]              mask_reg  [LAT];
    logic [IW-1:0]              idx_reg   [LAT];
    logic                       oor_reg   [LAT];

    logic [VW-1:0]              dir [ML];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= rtg_pkg::IMG_W'(640);
            image_height_reg <= rtg_pkg::IMG_W'(480);
            tiles_across_reg <= rtg_pkg::TCNT_W'(320);
            tiles_down_reg   <= rtg_pkg::TCNT_W'(240);
            top_left_reg     <= '0;
            right_step_reg   <= '0;
            up_step_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rtg_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[rtg_pkg::IMG_W-1:0];
                rtg_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[rtg_pkg::IMG_W-1:0];
                rtg_pkg::REG_TILES_ACROSS: tiles_across_reg <= cfg_data[rtg_pkg::TCNT_W-1:0];
                rtg_pkg::REG_TILES_DOWN:   tiles_down_reg   <= cfg_data[rtg_pkg::TCNT_W-1:0];
                rtg_pkg::REG_TOP_LEFT:     top_left_reg     <= cfg_data;
                rtg_pkg::REG_RIGHT_STEP:   right_step_reg   <= cfg_data;
                rtg_pkg::REG_UP_STEP:      up_step_reg      <= cfg_data;
                default:                   ;
            endcase
        end
    end

    assign en       = !valid_reg[LAT-1] || out_ready;
    assign in_ready = en;

    assign oor = (rtg_pkg::TCNT_W'(tile_column) >= tiles_across_reg)
              || (rtg_pkg::TCNT_W'(tile_row) >= tiles_down_reg);

    assign w_sat = (SDW'(image_width_reg) > SDW'(MAX_IMAGE_SIDE))
                   ? SDW'(MAX_IMAGE_SIDE) : SDW'(image_width_reg);
    assign h_sat = (SDW'(image_height_reg) > SDW'(MAX_IMAGE_SIDE))
                   ? SDW'(MAX_IMAGE_SIDE) : SDW'(image_height_reg);

    assign idx_prod = PROD_I'(tile_row) * PROD_I'(tiles_across_reg) + PROD_I'(tile_column);
    assign idx_next = oor ? '0 : IW'(idx_prod);

    genvar l;
    generate
        for (l = 0; l < ML; l++)
        begin : g_lane
            if (l < NL)
            begin : g_on
                rtg_pkg::lane_req_t req;

                assign req.px  = PXW'(tile_column) * PXW'(RAYS_ACROSS) + PXW'(l % RAYS_ACROSS);
                assign req.py  = PXW'(tile_row) * PXW'(RAYS_DOWN) + PXW'(l / RAYS_ACROSS);
                assign req.act = !oor && (SDW'(req.px) < w_sat) && (SDW'(req.py) < h_sat);
                assign mask_next[l] = req.act;

                rtg_lane u_lane (
                    .clk               (clk),
                    .en                (en),
                    .req               (req),
                    .top_left_vector   (top_left_reg),
                    .right_step_vector (right_step_reg),
                    .up_step_vector    (up_step_reg),
                    .direction         (dir[l])
                );
            end
            else
            begin : g_off
                assign mask_next[l] = 1'b0;
                assign dir[l]       = '0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < LAT; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < LAT; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mask_reg[0] <= mask_next;
            idx_reg[0]  <= idx_next;
            oor_reg[0]  <= oor;
            for (int s = 1; s < LAT; s++)
            begin
                mask_reg[s] <= mask_reg[s-1];
                idx_reg[s]  <= idx_reg[s-1];
                oor_reg[s]  <= oor_reg[s-1];
            end
        end
    end

    assign out_valid         = valid_reg[LAT-1];
    assign active_mask       = mask_reg[LAT-1];
    assign packet_index      = idx_reg[LAT-1];
    assign tile_out_of_range = oor_reg[LAT-1];
    assign lane0_direction   = dir[0];
    assign lane1_direction   = dir[1];
    assign lane2_direction   = dir[2];
    assign lane3_direction   = dir[3];

`ifndef SYNTHESIS
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tile_out_of_range |-> (active_mask == '0) && (packet_index == '0))
        else $error("out-of-range tile with nonzero mask or index");

    a_lane0_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !active_mask[0] |-> (lane0_direction == '0))
        else $error("inactive lane 0 with nonzero direction");

    a_lane3_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !active_mask[3] |-> (lane3_direction == '0))
        else $error("inactive lane 3 with nonzero direction");

    a_mask_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((active_mask >> NL) == '0))
        else $error("mask bit set beyond built lanes");
`endif

endmodule

>>> design/rtg_isqrt.sv
// Pipelined integer square root, one result bit per stage
module rtg_isqrt #(
    parameter int TAG_W = 1
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [rtg_pkg::SUM_W-1:0]     radicand,
    input  logic [TAG_W-1:0]              tag_in,
    output logic [rtg_pkg::ROOT_W-1:0]    root,
    output logic [TAG_W-1:0]              tag_out
);

    localparam int N  = rtg_pkg::ROOT_W;
    localparam int RW = rtg_pkg::SUM_W;
    localparam int TW = RW + 1;

    logic [RW-1:0]    rem_reg  [N];
    logic [N-1:0]     root_reg [N];
    logic [TAG_W-1:0] tag_reg  [N];

    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_stage
            localparam int B = N - 1 - g;
            logic [RW-1:0]    rem_in;
            logic [N-1:0]     root_in;
            logic [TAG_W-1:0] tag_i;
            logic [TW-1:0]    trial;

            if (g == 0)
            begin : g_first
                assign rem_in  = radicand;
                assign root_in = '0;
                assign tag_i   = tag_in;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[g-1];
                assign root_in = root_reg[g-1];
                assign tag_i   = tag_reg[g-1];
            end

            assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tag_reg[g] <= tag_i;
                    if (TW'(rem_in) >= trial)
                    begin
                        rem_reg[g]  <= RW'(TW'(rem_in) - trial);
                        root_reg[g] <= root_in | (N'(1) << B);
                    end
                    else
                    begin
                        rem_reg[g]  <= rem_in;
                        root_reg[g] <= root_in;
                    end
                end
            end
        end
    endgenerate

    assign root    = root_reg[N-1];
    assign tag_out = tag_reg[N-1];

endmodule

>>> design/rtg_div.sv
// Pipelined restoring divider, one quotient bit per stage
module rtg_div #(
    parameter int TAG_W = 1
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [rtg_pkg::NUM_W-1:0]     num,
    input  logic [rtg_pkg::ROOT_W-1:0]    den,
    input  logic [TAG_W-1:0]              tag_in,
    output logic [rtg_pkg::Q_W-1:0]       quot,
    output logic [TAG_W-1:0]              tag_out
);

    localparam int QW = rtg_pkg::Q_W;
    localparam int DW = rtg_pkg::ROOT_W;
    localparam int NW = rtg_pkg::NUM_W;

    logic [DW-1:0]    rem_reg [QW+1];
    logic [QW-1:0]    low_reg [QW+1];
    logic [DW-1:0]    den_reg [QW+1];
    logic [QW-1:0]    q_reg   [QW+1];
    logic [TAG_W-1:0] tag_reg [QW+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DW'(num[NW-1:QW]);
            low_reg[0] <= num[QW-1:0];
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            tag_reg[0] <= tag_in;
        end
    end

    genvar g;
    generate
        for (g = 1; g <= QW; g++)
        begin : g_stage
            localparam int B = QW - g;
            logic [DW:0] shifted;

            assign shifted = {rem_reg[g-1], low_reg[g-1][B]};

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    low_reg[g] <= low_reg[g-1];
                    den_reg[g] <= den_reg[g-1];
                    tag_reg[g] <= tag_reg[g-1];
                    if (shifted >= {1'b0, den_reg[g-1]})
                    begin
                        rem_reg[g] <= DW'(shifted - {1'b0, den_reg[g-1]});
                        q_reg[g]   <= q_reg[g-1] | (QW'(1) << B);
                    end
                    else
                    begin
                        rem_reg[g] <= DW'(shifted);
                        q_reg[g]   <= q_reg[g-1];
                    end
                end
            end
        end
    endgenerate

    assign quot    = q_reg[QW];
    assign tag_out = tag_reg[QW];

endmodule

>>> design/rtg_lane.sv
// One ray lane: direction sum, scaling, length and normalized components
module rtg_lane (
    input  logic                       clk,
    input  logic                       en,
    input  rtg_pkg::lane_req_t         req,
    input  logic [rtg_pkg::VEC_W-1:0]  top_left_vector,
    input  logic [rtg_pkg::VEC_W-1:0]  right_step_vector,
    input  logic [rtg_pkg::VEC_W-1:0]  up_step_vector,
    output logic [rtg_pkg::VEC_W-1:0]  direction
);

    localparam int CW   = rtg_pkg::COMP_W;
    localparam int PW   = rtg_pkg::PROD_W;
    localparam int TW   = rtg_pkg::T_W;
    localparam int MW   = rtg_pkg::MAG_W;
    localparam int SW   = rtg_pkg::SH_W;
    localparam int M30  = rtg_pkg::M30_W;
    localparam int QSW  = rtg_pkg::SQ_W;
    localparam int SUMW = rtg_pkg::SUM_W;
    localparam int RW   = rtg_pkg::ROOT_W;
    localparam int NW   = rtg_pkg::NUM_W;
    localparam int QW   = rtg_pkg::Q_W;
    localparam int FW   = rtg_pkg::FRAC_W;
    localparam int PXW  = rtg_pkg::PIX_W;
    localparam int STW  = 3 * M30 + 3 + 1;

    logic signed [CW-1:0] tl_c [3];
    logic signed [CW-1:0] rs_c [3];
    logic signed [CW-1:0] us_c [3];

    logic signed [CW-1:0] tl_reg [3];
    logic signed [PW-1:0] pr_reg [3];
    logic signed [PW-1:0] pu_reg [3];
    logic                 act1_reg;

    logic signed [TW-1:0] t_sum [3];
    logic [MW-1:0]        mag2_reg [3];
    logic [2:0]           neg2_reg;
    logic                 act2_reg;

    logic [MW-1:0]        m_next;
    logic [MW-1:0]        m_reg;
    logic [MW-1:0]        mag3_reg [3];
    logic [2:0]           neg3_reg;
    logic                 act3_reg;

    logic [SW-1:0]        sh;
    logic [M30-1:0]       mag4_reg [3];
    logic [2:0]           neg4_reg;
    logic                 zero4_reg;

    logic [QSW-1:0]       sq_reg [3];
    logic [M30-1:0]       mag5_reg [3];
    logic [2:0]           neg5_reg;
    logic                 zero5_reg;

    logic [SUMW-1:0]      sum_reg;
    logic [M30-1:0]       mag6_reg [3];
    logic [2:0]           neg6_reg;
    logic                 zero6_reg;

    logic [STW-1:0]       sq_tag_in;
    logic [STW-1:0]       sq_tag_out;
    logic [RW-1:0]        root;
    logic                 zero7;

    logic [QW-1:0]        quot [3];
    logic [1:0]           dv_tag [3];
    logic [CW-1:0]        dir_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            tl_c[k] = $signed(top_left_vector[CW*k +: CW]);
            rs_c[k] = $signed(right_step_vector[CW*k +: CW]);
            us_c[k] = $signed(up_step_vector[CW*k +: CW]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                tl_reg[k] <= tl_c[k];
                pr_reg[k] <= PW'($signed({1'b0, req.px})) * PW'(rs_c[k]);
                pu_reg[k] <= PW'($signed({1'b0, req.py})) * PW'(us_c[k]);
            end
            act1_reg <= req.act;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            t_sum[k] = TW'(tl_reg[k]) + TW'(pr_reg[k]) + TW'(pu_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                neg2_reg[k] <= t_sum[k][TW-1];
                mag2_reg[k] <= t_sum[k][TW-1] ? MW'(-t_sum[k]) : MW'(t_sum[k]);
            end
            act2_reg <= act1_reg;
        end
    end

    always_comb
    begin
        m_next = mag2_reg[0];
        if (mag2_reg[1] > m_next)
        begin
            m_next = mag2_reg[1];
        end
        if (mag2_reg[2] > m_next)
        begin
            m_next = mag2_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg    <= m_next;
            mag3_reg <= mag2_reg;
            neg3_reg <= neg2_reg;
            act3_reg <= act2_reg;
        end
    end

    always_comb
    begin
        sh = '0;
        for (int b = MW - 1; b >= M30; b--)
        begin
            if (m_reg[b] && (sh == '0))
            begin
                sh = SW'(b - M30 + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mag4_reg[k] <= M30'(mag3_reg[k] >> sh);
            end
            neg4_reg  <= neg3_reg;
            zero4_reg <= !act3_reg || (m_reg == '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k] <= QSW'(mag4_reg[k]) * QSW'(mag4_reg[k]);
            end
            mag5_reg  <= mag4_reg;
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg   <= SUMW'(sq_reg[0]) + SUMW'(sq_reg[1]) + SUMW'(sq_reg[2]);
            mag6_reg  <= mag5_reg;
            neg6_reg  <= neg5_reg;
            zero6_reg <= zero5_reg;
        end
    end

    assign sq_tag_in = {mag6_reg[2], mag6_reg[1], mag6_reg[0], neg6_reg, zero6_reg};

    rtg_isqrt #(
        .TAG_W (STW)
    ) u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (sum_reg),
        .tag_in   (sq_tag_in),
        .root     (root),
        .tag_out  (sq_tag_out)
    );

    assign zero7 = sq_tag_out[0] || (root == '0);

    genvar k;
    generate
        for (k = 0; k < 3; k++)
        begin : g_comp
            logic [M30-1:0] mag_c;
            logic [NW-1:0]  num;

            assign mag_c = sq_tag_out[4 + M30*k +: M30];
            assign num   = NW'({mag_c, {FW{1'b0}}}) + NW'(root >> 1);

            rtg_div #(
                .TAG_W (2)
            ) u_div (
                .clk     (clk),
                .en      (en),
                .num     (num),
                .den     (root),
                .tag_in  ({sq_tag_out[1 + k], zero7}),
                .quot    (quot[k]),
                .tag_out (dv_tag[k])
            );

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (dv_tag[k][0])
                    begin
                        dir_reg[k] <= '0;
                    end
                    else if (dv_tag[k][1])
                    begin
                        dir_reg[k] <= CW'(-{1'b0, quot[k]});
                    end
                    else
                    begin
                        dir_reg[k] <= CW'({1'b0, quot[k]});
                    end
                end
            end
        end
    endgenerate

    assign direction = {dir_reg[2], dir_reg[1], dir_reg[0]};

endmodule
